>>> rtl/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, constants and character helpers for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int NUMBER_W           = 32;
    localparam int CHAR_W             = 8;
    localparam int ROMAN_LIMIT        = 3999;
    localparam int ROMAN_PLACES       = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_I    = 8'h49;
    localparam logic [CHAR_W-1:0] ASCII_V    = 8'h56;
    localparam logic [CHAR_W-1:0] ASCII_X    = 8'h58;
    localparam logic [CHAR_W-1:0] ASCII_L    = 8'h4C;
    localparam logic [CHAR_W-1:0] ASCII_C    = 8'h43;
    localparam logic [CHAR_W-1:0] ASCII_D    = 8'h44;
    localparam logic [CHAR_W-1:0] ASCII_M    = 8'h4D;

    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_FIVE,
        SEL_TEN
    } roman_sel_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic prep;
        logic emit;
    } rne_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic zero;
        logic emit_end;
    } rne_sts_t;

    // Number of letters that one decimal digit takes in Roman form.
    function automatic logic [2:0] roman_len(input logic [3:0] digit);
        logic [2:0] len;
        unique case (digit)
            4'd0:    len = 3'd0;
            4'd1:    len = 3'd1;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd3;
            4'd4:    len = 3'd2;
            4'd5:    len = 3'd1;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd3;
            4'd8:    len = 3'd4;
            4'd9:    len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Which of the place's three letters stands at a given offset in the digit.
    function automatic roman_sel_t roman_sel(input logic [3:0] digit, input logic [2:0] offset);
        roman_sel_t sel;
        sel = SEL_ONE;
        if (digit == 4'd4 && offset == 3'd1) begin
            sel = SEL_FIVE;
        end else if (digit == 4'd9 && offset == 3'd1) begin
            sel = SEL_TEN;
        end else if (digit >= 4'd5 && digit <= 4'd8 && offset == 3'd0) begin
            sel = SEL_FIVE;
        end
        return sel;
    endfunction

    function automatic logic [CHAR_W-1:0] roman_letter(input logic [1:0] place,
                                                       input roman_sel_t sel);
        logic [CHAR_W-1:0] ch;
        unique case (place)
            2'd0: begin
                unique case (sel)
                    SEL_ONE:  ch = ASCII_I;
                    SEL_FIVE: ch = ASCII_V;
                    default:  ch = ASCII_X;
                endcase
            end
            2'd1: begin
                unique case (sel)
                    SEL_ONE:  ch = ASCII_X;
                    SEL_FIVE: ch = ASCII_L;
                    default:  ch = ASCII_C;
                endcase
            end
            2'd2: begin
                unique case (sel)
                    SEL_ONE:  ch = ASCII_C;
                    SEL_FIVE: ch = ASCII_D;
                    default:  ch = ASCII_M;
                endcase
            end
            default: ch = ASCII_M;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/roman_numeral_encoder_top.sv
// Sequence: the item is taken, converted to BCD four bits at a time, the cursor is
// placed, then one character is emitted per cycle while the output is not stalled.
// Roman text also steps over each zero digit above its last letter, emitting nothing.
// One item at a time: the next item is taken only after the last character has
// entered the result register; a zero value finishes after conversion.
// Reset (aresetn, synchronous, active low) empties the output and idles the FSM.
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top
// Converts one unsigned number per item into Roman numeral text (or decimal
// digits above 3999), one ASCII character per result item.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top
    import rne_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [NUMBER_W-1:0] s_number_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_char_out,
    output logic                m_last_char
);

    rne_cmd_t cmd;
    rne_sts_t sts;

    rne_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rne_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .number_in   (s_number_in),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_last_char (m_last_char)
    );

endmodule

>>> rtl/rne_ctrl.sv
// ----------------------------------------------------------------------------
// rne_ctrl
// Sequencer: accepts an item, runs the binary to BCD conversion, then drives character
// emission until the datapath reports the final character (a zero returns to idle).
// ----------------------------------------------------------------------------
module rne_ctrl
    import rne_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rne_sts_t sts,
    output rne_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_CONV;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_CONV: begin
                    if (sts.conv_last) begin
                        if (sts.zero) begin
                            state_reg   <= ST_IDLE;
                            s_ready_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (sts.emit_end) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        cmd       = '0;
        cmd.load  = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        cmd.shift = (state_reg == ST_CONV);
        cmd.prep  = (state_reg == ST_PREP);
        cmd.emit  = (state_reg == ST_EMIT);
    end

    assign s_ready = s_ready_reg;

endmodule

>>> rtl/rne_datapath.sv
// ----------------------------------------------------------------------------
// rne_datapath
// Shift-and-add-3 BCD converter (four bits per cycle), emission cursor over
// the BCD digits, and the result register.
// ----------------------------------------------------------------------------
module rne_datapath
    import rne_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [NUMBER_W-1:0] number_in,
    input  rne_cmd_t            cmd,
    output rne_sts_t            sts,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_char_out,
    output logic                m_last_char
);

    localparam int IN_BITS = (VALUE_BITS < NUMBER_W) ? VALUE_BITS : NUMBER_W;
    localparam int STEPS   = (IN_BITS + 3) / 4;
    localparam int BIN_W   = STEPS * 4;
    localparam int NDIG    = ((IN_BITS * 1233) >> 12) + 1;
    localparam int BCD_W   = NDIG * 4;
    localparam int CNT_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int POS_W   = $clog2(NDIG);

    logic [BIN_W-1:0]  bin_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              roman_reg;
    logic              zero_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [2:0]        k_reg;
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_char_reg;
    logic              m_last_reg;

    logic [IN_BITS-1:0] value_in;
    logic [BIN_W-1:0]   bin_next;
    logic [BCD_W-1:0]   bcd_next;
    logic [POS_W-1:0]   msd_pos;
    logic [3:0]         cur_digit;
    logic [2:0]         cur_len;
    logic [CHAR_W-1:0]  cur_char;
    logic               lower_zero;
    logic               at_last_pos;
    logic               k_last;
    logic               char_vld;
    logic               out_free;
    logic               step;
    logic               step_end;

    assign value_in = number_in[IN_BITS-1:0];

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        for (int b = 0; b < 4; b++) begin
            for (int g = 0; g < NDIG; g++) begin
                if (bcd_next[g*4 +: 4] >= 4'd5) begin
                    bcd_next[g*4 +: 4] = bcd_next[g*4 +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], bin_next[BIN_W-1]};
            bin_next = {bin_next[BIN_W-2:0], 1'b0};
        end
    end

    always_comb begin
        msd_pos = '0;
        for (int g = 0; g < NDIG; g++) begin
            if (bcd_reg[g*4 +: 4] != 4'd0) begin
                msd_pos = POS_W'(g);
            end
        end
    end

    assign cur_digit = bcd_reg[pos_reg*4 +: 4];

    always_comb begin
        lower_zero = 1'b0;
        unique case (pos_reg[1:0])
            2'd0:    lower_zero = 1'b1;
            2'd1:    lower_zero = (bcd_reg[3:0] == 4'd0);
            2'd2:    lower_zero = (bcd_reg[7:0] == 8'd0);
            default: lower_zero = (bcd_reg[11:0] == 12'd0);
        endcase
        if (roman_reg) begin
            cur_len     = roman_len(cur_digit);
            cur_char    = roman_letter(pos_reg[1:0], roman_sel(cur_digit, k_reg));
            at_last_pos = lower_zero;
        end else begin
            cur_len     = 3'd1;
            cur_char    = ASCII_ZERO + {4'd0, cur_digit};
            at_last_pos = (pos_reg == '0);
        end
    end

    assign k_last   = (cur_len == 3'd0) || (k_reg == cur_len - 3'd1);
    assign char_vld = (k_reg < cur_len);
    assign out_free = !m_valid_reg || m_ready;
    assign step     = cmd.emit && out_free;
    assign step_end = k_last && at_last_pos;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg   <= BIN_W'(value_in);
            bcd_reg   <= '0;
            cnt_reg   <= '0;
            roman_reg <= (value_in <= IN_BITS'(ROMAN_LIMIT));
            zero_reg  <= (value_in == '0);
        end else if (cmd.shift) begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.prep) begin
            pos_reg <= roman_reg ? POS_W'(ROMAN_PLACES - 1) : msd_pos;
            k_reg   <= 3'd0;
        end else if (step) begin
            if (k_last) begin
                pos_reg <= pos_reg - 1'b1;
                k_reg   <= 3'd0;
            end else begin
                k_reg <= k_reg + 3'd1;
            end
        end
        if (step && char_vld) begin
            m_char_reg <= cur_char;
            m_last_reg <= step_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step && char_vld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.conv_last = (cnt_reg == CNT_W'(STEPS - 1));
    assign sts.zero      = zero_reg;
    assign sts.emit_end  = step && step_end;

    assign m_valid     = m_valid_reg;
    assign m_char_out  = m_char_reg;
    assign m_last_char = m_last_reg;

endmodule

>>> rtl/rne_checker.sv
// ----------------------------------------------------------------------------
// rne_checker
// Port-level checks for the Roman numeral encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rne_checker
    import rne_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [CHAR_W-1:0]   m_char_out,
    input logic                m_last_char
);

    logic out_char_legal;

    assign out_char_legal = (m_char_out == ASCII_M) || (m_char_out == ASCII_D)
                         || (m_char_out == ASCII_C) || (m_char_out == ASCII_L)
                         || (m_char_out == ASCII_X) || (m_char_out == ASCII_V)
                         || (m_char_out == ASCII_I)
                         || ((m_char_out >= ASCII_ZERO) && (m_char_out <= ASCII_ZERO + 8'd9));

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_out) && $stable(m_last_char))
        else $error("Result item changed while stalled.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input taken while an item is still in conversion.");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("Result item appeared before conversion could finish.");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> out_char_legal)
        else $error("Result item carries a character outside the numeral set.");

    a_busy_mid_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_char |-> !s_ready)
        else $error("Input ready while a value's text is still being emitted.");

endmodule

bind roman_numeral_encoder_top rne_checker u_rne_checker (.*);

>>> dv/roman_numeral_encoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top_tb
// Feeds numbers into the encoder and checks every emitted character and its
// last flag against an in-bench predictor that builds the Roman text by
// greedy subtraction, or the decimal digits above 3999. Runs a directed set
// and then random numbers across four flow-control phases.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top_tb;
    import rne_pkg::*;

    localparam int VALUE_BITS = DEFAULT_VALUE_BITS;
    localparam int RANDOM_PER_PHASE = 99;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [NUMBER_W-1:0] s_number_in = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CHAR_W-1:0]   m_char_out;
    logic                m_last_char;

    logic [NUMBER_W-1:0] numbers_to_send[$];
    text_char_t          expected_text[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned numbers_queued = 0;
    int unsigned numbers_accepted = 0;
    int unsigned roman_count = 0;
    int unsigned decimal_count = 0;
    int unsigned zero_count = 0;
    int unsigned chars_checked = 0;
    int unsigned mismatch_count = 0;

    int unsigned roman_weight[13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    string       roman_mark[13] = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX",
                                    "V", "IV", "I"};
    int unsigned phase_send_idle[4] = '{0, 84, 0, 38};
    int unsigned phase_recv_stall[4] = '{0, 0, 84, 38};

    roman_numeral_encoder_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_number_in(s_number_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_out (m_char_out),
        .m_last_char(m_last_char)
    );

    always #4 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 25) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Appends the characters that one accepted number should produce.
    function automatic void predict_text(input logic [NUMBER_W-1:0] num);
        logic [NUMBER_W-1:0] value;
        logic [CHAR_W-1:0]   text[$];
        int unsigned         rest;
        int                  s;
        text_char_t          item;
        value = (VALUE_BITS >= NUMBER_W) ? num : (num & ((32'd1 << VALUE_BITS) - 32'd1));
        if (value > ROMAN_LIMIT) begin
            decimal_count++;
            while (value != 0) begin
                text.push_front(ASCII_ZERO + CHAR_W'(value % 10));
                value = value / 10;
            end
        end else begin
            if (value == 0) begin
                zero_count++;
            end else begin
                roman_count++;
            end
            rest = value;
            s = 0;
            while (rest > 0 && s < 13) begin
                if (rest >= roman_weight[s]) begin
                    for (int k = 0; k < roman_mark[s].len(); k++) begin
                        text.push_back(roman_mark[s][k]);
                    end
                    rest -= roman_weight[s];
                end else begin
                    s++;
                end
            end
        end
        for (int k = 0; k < text.size(); k++) begin
            item.ch = text[k];
            item.last = (k == text.size() - 1);
            expected_text.push_back(item);
        end
    endfunction

    function automatic void queue_number(input logic [NUMBER_W-1:0] num);
        numbers_to_send.push_back(num);
        numbers_queued++;
    endfunction

    function automatic logic [NUMBER_W-1:0] random_number();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6) begin
            return '0;
        end else if (pick < 60) begin
            return $urandom_range(1, ROMAN_LIMIT);
        end else if (pick < 72) begin
            return $urandom_range(3000, ROMAN_LIMIT);
        end else if (pick < 76) begin
            return $urandom_range(3990, 4010);
        end else if (pick < 92) begin
            return $urandom >> $urandom_range(0, 20);
        end
        return $urandom;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_number_in <= '0;
        end else begin
            if (s_valid && s_ready) begin
                predict_text(s_number_in);
                numbers_accepted++;
            end
            if ((!s_valid || s_ready) && numbers_to_send.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_number_in <= numbers_to_send.pop_front();
            end else if (!s_valid || s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        text_char_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                chars_checked++;
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                              m_char_out, m_last_char));
                end else begin
                    want = expected_text.pop_front();
                    if (m_char_out !== want.ch) begin
                        report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
                                                  m_char_out, want.ch));
                    end
                    if (m_last_char !== want.last) begin
                        report_mismatch($sformatf("last_char %0b, expected %0b for 0x%02h",
                                                  m_last_char, want.last, want.ch));
                    end
                end
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("Timed out with %0d characters still expected.", expected_text.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            if (p == 0) begin
                queue_number(32'd0);
                queue_number(32'd1);
                queue_number(32'd3);
                queue_number(32'd4);
                queue_number(32'd5);
                queue_number(32'd9);
                queue_number(32'd10);
                queue_number(32'd40);
                queue_number(32'd49);
                queue_number(32'd50);
                queue_number(32'd90);
                queue_number(32'd100);
                queue_number(32'd400);
                queue_number(32'd500);
                queue_number(32'd900);
                queue_number(32'd1000);
                queue_number(32'd1994);
                queue_number(32'd3888);
                queue_number(32'd3999);
                queue_number(32'd4000);
                queue_number(32'd1000000000);
                queue_number(32'hAAAAAAAA);
                queue_number(32'h55555555);
                queue_number(32'hFFFFFFFF);
                queue_number(32'd0);
            end
            repeat (RANDOM_PER_PHASE) queue_number(random_number());
            do @(negedge aclk);
            while (numbers_accepted != numbers_queued || expected_text.size() != 0);
        end
        repeat (60) @(posedge aclk);
        $display("Converted %0d numbers: %0d Roman, %0d decimal, %0d zero.",
                 numbers_accepted, roman_count, decimal_count, zero_count);
        $display("Checked %0d characters over four flow-control phases, %0d mismatches.",
                 chars_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rne_pkg.sv
rtl/rne_ctrl.sv
rtl/rne_datapath.sv
rtl/roman_numeral_encoder_top.sv
rtl/rne_checker.sv
dv/roman_numeral_encoder_top_tb.sv
